/* rtl/shfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_pkg
// Shared constants and controller/datapath signal groups of the
// sync-header frame receiver.
// ----------------------------------------------------------------------------
package shfr_pkg;

    localparam int unsigned MAX_FRAME_DEF = 64;

    localparam logic [7:0] SYNC_BYTE      = 8'h7E;
    localparam logic [7:0] HDR_SECOND     = 8'h00;
    localparam logic [7:0] HDR_THIRD      = 8'h10;
    localparam int unsigned BODY_FIXED_END = 10;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LENGTH_W = 7;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic len_load;
        logic load_out;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic is_sync;
        logic is_second;
        logic is_third;
        logic out_free;
    } t_status;

endpackage

/* rtl/sync_header_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_receiver
// Rebuilds sync-header frames from a received byte stream and replays them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) takes one received
//   byte per request, one per cycle while a frame is being collected.
//   A frame opens with 7E 00 10; from position 10 on a 7E byte ends it.
//   Frames that reach MAX_FRAME bytes without a terminator are dropped.
//   Output channel (o_frame_valid / i_frame_stall) replays the stored frame,
//   header to terminator, with the length on every byte and a last flag.
// Timing:
//   After the terminator is accepted, each burst byte goes through the
//   buffer read port, then the output register. The input is stalled
//   during the burst and is released as soon as the last byte sits in
//   the output register. A stalled output holds its byte; the next
//   buffer read waits for it.
// Reset:
//   Synchronous, active low; returns to header search with no output
//   pending. The frame buffer needs no clearing.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver
    import shfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_stall,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    output logic                o_frame_valid,
    input  logic                i_frame_stall,
    output logic [BYTE_W-1:0]   o_frame_byte,
    output logic [LENGTH_W-1:0] o_frame_length,
    output logic                o_frame_last
);

    localparam int unsigned PW = $clog2(MAX_FRAME);
    localparam int unsigned LW = $clog2(MAX_FRAME + 1);

    t_cmd          cmd;
    t_status       status;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic [LW-1:0] len;

    shfr_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_len      (len)
    );

    shfr_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .i_wr_addr      (wr_addr),
        .i_rd_addr      (rd_addr),
        .i_len          (len),
        .o_status       (status),
        .o_frame_valid  (o_frame_valid),
        .i_frame_stall  (i_frame_stall),
        .o_frame_byte   (o_frame_byte),
        .o_frame_length (o_frame_length),
        .o_frame_last   (o_frame_last)
    );

endmodule

/* rtl/shfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/shfr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_datapath
// Byte matching, frame buffer, length register and output register.
// ----------------------------------------------------------------------------
module shfr_datapath
    import shfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [BYTE_W-1:0]               i_rx_byte,
    input  t_cmd                            i_cmd,
    input  logic [$clog2(MAX_FRAME)-1:0]    i_wr_addr,
    input  logic [$clog2(MAX_FRAME)-1:0]    i_rd_addr,
    input  logic [$clog2(MAX_FRAME+1)-1:0]  i_len,
    output t_status                         o_status,
    output logic                            o_frame_valid,
    input  logic                            i_frame_stall,
    output logic [BYTE_W-1:0]               o_frame_byte,
    output logic [LENGTH_W-1:0]             o_frame_length,
    output logic                            o_frame_last
);

    localparam int unsigned LW = $clog2(MAX_FRAME + 1);

    logic [BYTE_W-1:0]   rd_data;
    logic [LW-1:0]       r_len;
    logic                r_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_last;
    logic [LENGTH_W-1:0] r_frame_len;

    shfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_valid <= 1'b1;
        end else if (r_valid && !i_frame_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.len_load) begin
            r_len <= i_len;
        end
        // hold the length with its byte so a new frame cannot alter a stalled request
        if (i_cmd.load_out) begin
            r_byte      <= rd_data;
            r_last      <= i_cmd.out_last;
            r_frame_len <= LENGTH_W'(r_len);
        end
    end

    assign o_status.is_sync   = (i_rx_byte == SYNC_BYTE);
    assign o_status.is_second = (i_rx_byte == HDR_SECOND);
    assign o_status.is_third  = (i_rx_byte == HDR_THIRD);
    assign o_status.out_free  = !r_valid || !i_frame_stall;

    assign o_frame_valid  = r_valid;
    assign o_frame_byte   = r_byte;
    assign o_frame_length = r_frame_len;
    assign o_frame_last   = r_last;

endmodule

/* rtl/shfr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfr_ctrl
// Header tracking, frame position counter and burst read-out sequencing.
// ----------------------------------------------------------------------------
module shfr_ctrl
    import shfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rx_valid,
    output logic                            o_rx_stall,
    input  t_status                         i_status,
    output t_cmd                            o_cmd,
    output logic [$clog2(MAX_FRAME)-1:0]    o_wr_addr,
    output logic [$clog2(MAX_FRAME)-1:0]    o_rd_addr,
    output logic [$clog2(MAX_FRAME+1)-1:0]  o_len
);

    localparam int unsigned PW = $clog2(MAX_FRAME);
    localparam int unsigned LW = $clog2(MAX_FRAME + 1);

    typedef enum logic [1:0] {
        S_COLLECT,
        S_READ,
        S_LOAD
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_rd_idx, n_rd_idx;
    logic [LW-1:0] r_len, n_len;

    logic          rx_acc;
    logic [LW-1:0] pos_next;
    logic          last_byte;

    assign rx_acc    = i_rx_valid && (r_state == S_COLLECT);
    assign pos_next  = LW'(r_pos) + LW'(1);
    assign last_byte = (LW'(r_rd_idx) + LW'(1)) == r_len;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_rd_idx = r_rd_idx;
        n_len    = r_len;
        o_cmd    = '0;
        o_wr_addr = r_pos;
        case (r_state)
            S_COLLECT: begin
                if (rx_acc) begin
                    case (r_pos)
                        PW'(0): begin
                            if (i_status.is_sync) begin
                                o_cmd.wr_en = 1'b1;
                                n_pos       = PW'(1);
                            end
                        end
                        PW'(1), PW'(2): begin
                            if ((r_pos == PW'(1) && i_status.is_second) ||
                                (r_pos == PW'(2) && i_status.is_third)) begin
                                o_cmd.wr_en = 1'b1;
                                n_pos       = PW'(pos_next);
                            end else if (i_status.is_sync) begin
                                // restart the header match on a fresh sync byte
                                o_cmd.wr_en = 1'b1;
                                o_wr_addr   = '0;
                                n_pos       = PW'(1);
                            end else begin
                                n_pos = '0;
                            end
                        end
                        default: begin
                            o_cmd.wr_en = 1'b1;
                            if (r_pos < PW'(BODY_FIXED_END) || !i_status.is_sync) begin
                                // drop the frame when the buffer fills up
                                if (pos_next == LW'(MAX_FRAME)) begin
                                    n_pos = '0;
                                end else begin
                                    n_pos = PW'(pos_next);
                                end
                            end else begin
                                o_cmd.len_load = 1'b1;
                                n_len    = pos_next;
                                n_pos    = '0;
                                n_rd_idx = '0;
                                n_state  = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_last = last_byte;
                if (last_byte) begin
                    n_state = S_COLLECT;
                end else begin
                    n_rd_idx = r_rd_idx + PW'(1);
                    n_state  = S_READ;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_COLLECT;
            r_pos    <= '0;
            r_rd_idx <= '0;
            r_len    <= '0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_rd_idx <= n_rd_idx;
            r_len    <= n_len;
        end
    end

    assign o_rx_stall = (r_state != S_COLLECT);
    assign o_rd_addr  = r_rd_idx;
    assign o_len      = n_len;

endmodule
